// File: src/triac_phase_angle_gate_timer_defines.svh
// Shared assertion macros for the gate timer RTL.
`ifndef TRIAC_PHASE_ANGLE_GATE_TIMER_DEFINES_SVH
`define TRIAC_PHASE_ANGLE_GATE_TIMER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define TPGT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define TPGT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/tpgt_pkg.sv
`default_nettype none

package tpgt_pkg;

  localparam int TS_BITS = 48;

  localparam logic [31:0] GATE_MIN_US  = 32'd50;
  localparam logic [31:0] NOISE_GAP_US = 32'd5000;
  localparam logic [31:0] IDLE_WAIT_US = 32'd100;
  localparam logic [31:0] TRAIL_MIN_US = 32'd10;
  localparam logic [15:0] FULL_DUTY    = 16'hFFFF;
  localparam logic [9:0]  MP_MAX       = 10'd1000;

  // Divisors and their scaled reciprocals; an estimate from these never exceeds n / D.
  localparam logic [15:0] DIV_DUTY  = 16'd65535;
  localparam logic [15:0] DIV_MILLE = 16'd1000;
  localparam logic [15:0] DIV_TEN   = 16'd10;
  localparam logic [31:0] RCP_DUTY  = 32'h8000_8000;   // 2^47 / 65535
  localparam logic [31:0] RCP_MILLE = 32'd2199023255;  // 2^41 / 1000
  localparam logic [31:0] RCP_TEN   = 32'hCCCC_CCCC;   // 2^35 / 10

  localparam int ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_DUTY = 2'd0,
    REG_MODE = 2'd1,
    REG_MINP = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_LEADING  = 2'd0,
    MODE_TRAILING = 2'd1,
    MODE_PULSE    = 2'd2
  } dim_mode_t;

  typedef struct packed {
    logic               cmd;
    logic [TS_BITS-1:0] now_us;
  } in_t;

  typedef struct packed {
    logic        gate;
    logic [31:0] wait_us;
    logic [31:0] half_period_us;
  } out_t;

  // Saturate a timestamp difference to 32 bits.
  function automatic logic [31:0] sat_ts(input logic [TS_BITS-1:0] v);
    logic [TS_BITS-1:0] hi;
    hi = v >> 32;
    if (hi != '0) begin
      return 32'hFFFF_FFFF;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[32]) begin
      return 32'hFFFF_FFFF;
    end
    return s[31:0];
  endfunction

endpackage

`default_nettype wire

// File: src/triac_phase_angle_gate_timer.sv
// Channel | Direction | Handshake           | Payload
// in      | request   | in_valid/in_ready   | in_data  (cmd, now_us)
// out     | result    | out_valid/out_ready | out_data (gate, wait_us, half_period_us)
// cfg     | APB write | psel/penable/pwrite | paddr, pwdata, prdata (pready tied high)
//
// A poll steps through S_PON, S_POFF and S_PWAIT, but skips them before any crossing or
// with full on or full off. A crossing ends at S_BRANCH with full on, full off or on the
// first cycle; else it divides by 65535 (trailing edge), by 1000 and 65535 (leading edge)
// or also by 10 (pulse). Each division: reciprocal multiply, back multiply, correction steps.
// Reset is synchronous: gate on, no crossing seen, timing and configuration registers cleared.
// A new request is taken while a finished result still waits in the output register;
// the sequencer holds in its last step only while that register is full and out_ready is low.
`default_nettype none
`include "triac_phase_angle_gate_timer_defines.svh"

module triac_phase_angle_gate_timer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire tpgt_pkg::in_t                 in_data,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      tpgt_pkg::out_t                out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tpgt_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output      logic [31:0]                   prdata,
  output      logic                          pready
);
  import tpgt_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0_0000_0000_0001,
    S_ELAP   = 13'b0_0000_0000_0010,
    S_CROSS  = 13'b0_0000_0000_0100,
    S_BRANCH = 13'b0_0000_0000_1000,
    S_MUL    = 13'b0_0000_0001_0000,
    S_EST    = 13'b0_0000_0010_0000,
    S_BACK   = 13'b0_0000_0100_0000,
    S_FIX    = 13'b0_0000_1000_0000,
    S_POST   = 13'b0_0001_0000_0000,
    S_PON    = 13'b0_0010_0000_0000,
    S_POFF   = 13'b0_0100_0000_0000,
    S_PWAIT  = 13'b0_1000_0000_0000,
    S_DONE   = 13'b1_0000_0000_0000
  } state_t;

  typedef enum logic [3:0] {
    PH_TRAIL = 4'b0001,
    PH_MIN   = 4'b0010,
    PH_LEAD  = 4'b0100,
    PH_TEN   = 4'b1000
  } phase_t;

  // configuration
  logic [15:0] duty;
  logic [1:0]  dim_mode;
  logic [9:0]  power_floor;

  // timing state
  logic [TS_BITS-1:0] last_crossing;
  logic [31:0]        period_us;
  logic [31:0]        on_time;
  logic [31:0]        off_time;
  logic               gate_level;
  logic               first_cycle;

  // sequencer and work registers
  state_t             state;
  phase_t             phase;
  logic               cmd_r;
  logic [TS_BITS-1:0] now_r;
  logic [31:0]        t_r;
  logic [31:0]        wait_r;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [15:0]        div_den;
  logic [47:0]        num;
  logic [31:0]        quot;
  logic [19:0]        rem;

  logic               cfg_wr;
  logic [63:0]        prod;
  logic [31:0]        est_q;
  logic [47:0]        num_left;
  logic [19:0]        den_ext;
  logic [9:0]         mp_sat;
  logic [31:0]        pulse_end;
  logic [31:0]        poll_wait;
  logic               duty_edge;
  logic               out_load;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      duty        <= '0;
      dim_mode    <= '0;
      power_floor <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_DUTY: duty        <= pwdata[15:0];
        REG_MODE: dim_mode    <= pwdata[1:0];
        REG_MINP: power_floor <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DUTY: prdata = {16'd0, duty};
      REG_MODE: prdata = {30'd0, dim_mode};
      REG_MINP: prdata = {22'd0, power_floor};
      default:  prdata = '0;
    endcase
  end

  // shared multiplier and constant-division datapath
  assign prod     = mul_a * mul_b;
  assign num_left = num - prod[47:0];
  assign den_ext  = {4'd0, div_den};

  always_comb begin
    case (phase)
      PH_TEN:  est_q = {3'd0, prod[63:35]};
      default: est_q = prod[62:31];
    endcase
  end

  assign mp_sat    = (power_floor > MP_MAX) ? MP_MAX : power_floor;
  assign pulse_end = sat_add(on_time, GATE_MIN_US);
  assign duty_edge = (duty == FULL_DUTY) || (duty == 16'd0);

  always_comb begin
    if (t_r < on_time) begin
      poll_wait = on_time - t_r;
    end else if (t_r < off_time) begin
      poll_wait = off_time - t_r;
    end else if (t_r >= period_us) begin
      poll_wait = IDLE_WAIT_US;
    end else begin
      poll_wait = period_us - t_r;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_TRAIL;
      last_crossing <= '0;
      period_us     <= '0;
      on_time       <= '0;
      off_time      <= '0;
      gate_level    <= 1'b1;
      first_cycle   <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r <= in_data.cmd;
            now_r <= in_data.now_us;
            state <= S_ELAP;
          end
        end
        S_ELAP: begin
          t_r    <= sat_ts(now_r - last_crossing);
          wait_r <= '0;
          if (cmd_r) begin
            last_crossing <= now_r;
            state         <= S_CROSS;
          end else if (last_crossing == '0 || duty_edge) begin
            state <= S_DONE;
          end else begin
            state <= S_PON;
          end
        end
        S_CROSS: begin
          // a short gap is noise: add it to the running period
          if (t_r > NOISE_GAP_US) begin
            period_us <= t_r;
          end else begin
            period_us <= sat_add(period_us, t_r);
          end
          state <= S_BRANCH;
        end
        S_BRANCH: begin
          if (duty == FULL_DUTY) begin
            gate_level <= 1'b1;
            state      <= S_DONE;
          end else if (first_cycle) begin
            first_cycle <= 1'b0;
            on_time     <= '0;
            off_time    <= period_us;
            state       <= S_DONE;
          end else if (duty == 16'd0) begin
            gate_level <= 1'b0;
            state      <= S_DONE;
          end else if (dim_mode == MODE_TRAILING) begin
            mul_a   <= period_us;
            mul_b   <= {16'd0, duty};
            div_den <= DIV_DUTY;
            phase   <= PH_TRAIL;
            state   <= S_MUL;
          end else begin
            mul_a   <= period_us;
            mul_b   <= {22'd0, mp_sat};
            div_den <= DIV_MILLE;
            phase   <= PH_MIN;
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          // keep the numerator; the reciprocal multiply takes its top 32 bits (47:16, or 41:10 for 1000)
          num <= prod[47:0];
          if (phase == PH_MIN) begin
            mul_a <= prod[41:10];
            mul_b <= RCP_MILLE;
          end else begin
            mul_a <= prod[47:16];
            mul_b <= RCP_DUTY;
          end
          state <= S_EST;
        end
        S_EST: begin
          quot  <= est_q;
          mul_a <= est_q;
          mul_b <= {16'd0, div_den};
          state <= S_BACK;
        end
        S_BACK: begin
          rem   <= num_left[19:0];
          state <= S_FIX;
        end
        S_FIX: begin
          // the estimate runs low by a few units: step it up
          if (rem >= den_ext) begin
            rem  <= rem - den_ext;
            quot <= quot + 32'd1;
          end else begin
            state <= S_POST;
          end
        end
        S_POST: begin
          case (phase)
            PH_TRAIL: begin
              on_time  <= 32'd1;
              off_time <= (quot < TRAIL_MIN_US) ? TRAIL_MIN_US : quot;
              state    <= S_DONE;
            end
            PH_MIN: begin
              mul_a   <= period_us - quot;
              mul_b   <= {16'd0, FULL_DUTY - duty};
              div_den <= DIV_DUTY;
              phase   <= PH_LEAD;
              state   <= S_MUL;
            end
            PH_LEAD: begin
              on_time <= (quot == 32'd0) ? 32'd1 : quot;
              if (dim_mode == MODE_PULSE) begin
                num     <= {16'd0, period_us};
                mul_a   <= period_us;
                mul_b   <= RCP_TEN;
                div_den <= DIV_TEN;
                phase   <= PH_TEN;
                state   <= S_EST;
              end else begin
                gate_level <= 1'b0;
                off_time   <= period_us;
                state      <= S_DONE;
              end
            end
            PH_TEN: begin
              off_time <= (pulse_end > quot) ? pulse_end : quot;
              state    <= S_DONE;
            end
            default: state <= S_DONE;
          endcase
        end
        S_PON: begin
          if (on_time != '0 && t_r >= on_time) begin
            on_time    <= '0;
            gate_level <= 1'b1;
            // stretch the gate pulse to its minimum width
            if (sat_add(t_r, GATE_MIN_US) > off_time) begin
              off_time <= sat_add(t_r, GATE_MIN_US);
            end
          end
          state <= S_POFF;
        end
        S_POFF: begin
          if (off_time != '0 && t_r >= off_time) begin
            off_time   <= '0;
            gate_level <= 1'b0;
          end
          state <= S_PWAIT;
        end
        S_PWAIT: begin
          wait_r <= poll_wait;
          state  <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_load) begin
            out_data.gate           <= gate_level;
            out_data.wait_us        <= wait_r;
            out_data.half_period_us <= period_us;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TPGT_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state != S_IDLE,
    "accepted request did not start the sequencer")
  `TPGT_ASSERT_NOW(a_est_not_over, state == S_BACK,
    prod[63:48] == 16'd0 && prod[47:0] <= num, "quotient estimate above the true quotient")
  `TPGT_ASSERT_NOW(a_rem_below_den, state == S_POST, rem < den_ext,
    "division remainder not below the divisor")
  `TPGT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid,
    "result dropped before it was taken")
  `TPGT_ASSERT_NEXT(a_full_on_gate, state == S_BRANCH && duty == FULL_DUTY, gate_level,
    "full duty crossing left the gate off")

endmodule

`default_nettype wire

// File: sim/tb_triac_phase_angle_gate_timer.sv
`default_nettype none

module tb_triac_phase_angle_gate_timer;
  import tpgt_pkg::*;

  localparam logic CMD_POLL  = 1'b0;
  localparam logic CMD_CROSS = 1'b1;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [31:0] PULSE_MIN = 32'd50;
  localparam logic [31:0] NOISE_MAX = 32'd5000;
  localparam logic [31:0] LATE_WAIT = 32'd100;
  localparam logic [31:0] TRAIL_MIN = 32'd10;
  localparam logic [15:0] DUTY_ALL  = 16'hFFFF;
  localparam logic [9:0]  MILLE_CAP = 10'd1000;

  localparam int SETTLE_CYCLES = 160;
  localparam int RANDOM_ITEMS  = 1650;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  triac_phase_angle_gate_timer uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #1 clk = ~clk;

  // Register mirror
  logic [15:0] duty_cfg;
  logic [1:0]  mode_cfg;
  logic [9:0]  minp_cfg;

  // Gate timer state
  logic [47:0] crossing_at;
  logic [31:0] half_period;
  logic [31:0] gate_on_at;
  logic [31:0] gate_off_at;
  logic        gate_now;
  logic        first_pending;

  in_t  req_q[$];
  out_t result_q[$];
  int unsigned n_items = 0;
  int unsigned errors = 0;
  bit calm = 1'b0;
  int unsigned in_hold = 0;
  int unsigned out_hold = 0;

  function automatic logic [31:0] clip32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(40, 200);
  endfunction

  task automatic gate_timer_step(input in_t req, output out_t res);
    logic [31:0] elapsed;
    logic [31:0] wait_left;
    logic [31:0] pa;
    logic [31:0] pb;
    logic [63:0] p64;
    logic [63:0] mp;
    logic [63:0] span;
    logic [63:0] t;
    wait_left = '0;
    if (req.cmd == CMD_CROSS) begin
      elapsed = clip32({16'b0, req.now_us - crossing_at});
      crossing_at = req.now_us;
      // short gaps are glitches: fold them into the period
      if (elapsed > NOISE_MAX) begin
        half_period = elapsed;
      end else begin
        half_period = clip32({32'b0, half_period} + {32'b0, elapsed});
      end
      p64 = {32'b0, half_period};
      if (duty_cfg == DUTY_ALL) begin
        gate_now = 1'b1;
      end else if (first_pending) begin
        first_pending = 1'b0;
        gate_on_at = '0;
        gate_off_at = half_period;
      end else if (duty_cfg == 16'd0) begin
        gate_now = 1'b0;
      end else if (mode_cfg == MODE_TRAILING) begin
        t = ({48'b0, duty_cfg} * p64) / 64'd65535;
        gate_on_at = 32'd1;
        gate_off_at = (t < {32'b0, TRAIL_MIN}) ? TRAIL_MIN : t[31:0];
      end else begin
        mp = (minp_cfg > MILLE_CAP) ? {54'b0, MILLE_CAP} : {54'b0, minp_cfg};
        span = p64 - (p64 * mp) / 64'd1000;
        t = ({48'b0, DUTY_ALL - duty_cfg} * span) / 64'd65535;
        gate_on_at = (t < 64'd1) ? 32'd1 : t[31:0];
        if (mode_cfg == MODE_PULSE) begin
          pa = clip32({32'b0, gate_on_at} + {32'b0, PULSE_MIN});
          pb = half_period / 32'd10;
          gate_off_at = (pa > pb) ? pa : pb;
        end else begin
          gate_now = 1'b0;
          gate_off_at = half_period;
        end
      end
    end else if (crossing_at != '0 && duty_cfg != DUTY_ALL && duty_cfg != 16'd0) begin
      elapsed = clip32({16'b0, req.now_us - crossing_at});
      if (gate_on_at != '0 && elapsed >= gate_on_at) begin
        // stretch the pulse to the minimum gate time
        pa = clip32({32'b0, elapsed} + {32'b0, PULSE_MIN});
        gate_on_at = '0;
        gate_now = 1'b1;
        if (pa > gate_off_at) gate_off_at = pa;
      end
      if (gate_off_at != '0 && elapsed >= gate_off_at) begin
        gate_off_at = '0;
        gate_now = 1'b0;
      end
      if (elapsed < gate_on_at) wait_left = gate_on_at - elapsed;
      else if (elapsed < gate_off_at) wait_left = gate_off_at - elapsed;
      else if (elapsed >= half_period) wait_left = LATE_WAIT;
      else wait_left = half_period - elapsed;
    end
    res.gate = gate_now;
    res.wait_us = wait_left;
    res.half_period_us = half_period;
  endtask

  // Request driver
  always @(posedge clk) begin : drive_req
    logic nv;
    out_t res;
    if (rst) begin
      in_valid <= 1'b0;
      in_hold <= 0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        gate_timer_step(in_data, res);
        result_q.push_back(res);
        nv = 1'b0;
      end
      if (!nv) begin
        if (in_hold != 0) begin
          in_hold <= in_hold - 1;
        end else if (req_q.size() != 0) begin
          in_data <= req_q.pop_front();
          nv = 1'b1;
          if (!calm) in_hold <= pick_gap();
        end
      end
      in_valid <= nv;
    end
  end

  // Result monitor
  always @(posedge clk) begin : check_result
    out_t exp_res;
    if (rst) begin
      out_ready <= 1'b0;
      out_hold <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: result with none pending: gate %0b wait %0d period %0d", $time,
                   out_data.gate, out_data.wait_us, out_data.half_period_us);
        end else begin
          exp_res = result_q.pop_front();
          if (out_data.gate !== exp_res.gate) begin
            errors++;
            $display("%0t: gate expected %0b actual %0b", $time, exp_res.gate, out_data.gate);
          end
          if (out_data.wait_us !== exp_res.wait_us) begin
            errors++;
            $display("%0t: wait_us expected %0d actual %0d", $time, exp_res.wait_us,
                     out_data.wait_us);
          end
          if (out_data.half_period_us !== exp_res.half_period_us) begin
            errors++;
            $display("%0t: half_period_us expected %0d actual %0d", $time,
                     exp_res.half_period_us, out_data.half_period_us);
          end
        end
      end
      if (out_hold != 0) begin
        out_hold <= out_hold - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_hold <= pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_req(input logic cmd, input logic [47:0] at);
    in_t req;
    req.cmd = cmd;
    req.now_us = at;
    req_q.push_back(req);
    n_items++;
  endtask

  // Returns on a falling edge once every request has been answered.
  task automatic wait_idle();
    @(negedge clk);
    while (req_q.size() != 0 || in_valid || result_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DUTY: duty_cfg = val[15:0];
      REG_MODE: mode_cfg = val[1:0];
      REG_MINP: minp_cfg = val[9:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Upper bits carry junk that the block must drop.
  task automatic set_config(input logic [15:0] d, input logic [1:0] m, input logic [9:0] p);
    logic [31:0] junk;
    junk = $urandom;
    reg_write(REG_DUTY, {junk[31:16], d});
    junk = $urandom;
    reg_write(REG_MODE, {junk[31:2], m});
    junk = $urandom;
    reg_write(REG_MINP, {junk[31:10], p});
  endtask

  initial begin : stimulus
    logic [47:0] cur;
    logic [31:0] hi;
    logic [31:0] off;
    logic [15:0] d;
    logic [9:0] p;
    int unsigned hp;
    int unsigned k;
    int unsigned r;
    duty_cfg = '0;
    mode_cfg = '0;
    minp_cfg = '0;
    crossing_at = '0;
    half_period = '0;
    gate_on_at = '0;
    gate_off_at = '0;
    gate_now = 1'b1;
    first_pending = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: poll before any crossing, crossing at zero, glitch, wrap
    push_req(CMD_POLL, 48'd123);
    push_req(CMD_CROSS, 48'd0);
    push_req(CMD_POLL, 48'd50);
    push_req(CMD_CROSS, 48'd3000);
    push_req(CMD_CROSS, 48'd13000);
    push_req(CMD_POLL, 48'd13500);
    push_req(CMD_CROSS, 48'hFFFF_FFFF_FFFF);
    push_req(CMD_CROSS, 48'd9999);
    wait_idle();
    set_config(DUTY_ALL, MODE_LEADING, 10'd0);
    push_req(CMD_CROSS, 48'd20000);
    push_req(CMD_POLL, 48'd25000);
    wait_idle();
    set_config(16'd32768, MODE_LEADING, 10'd100);
    push_req(CMD_CROSS, 48'd30000);
    push_req(CMD_POLL, 48'd30001);
    push_req(CMD_POLL, 48'd34600);
    push_req(CMD_POLL, 48'd36000);
    push_req(CMD_POLL, 48'd41000);
    wait_idle();
    set_config(16'd1, MODE_TRAILING, 10'd0);
    push_req(CMD_CROSS, 48'd40000);
    push_req(CMD_POLL, 48'd40005);
    push_req(CMD_POLL, 48'd40100);
    wait_idle();
    set_config(16'd65534, MODE_PULSE, 10'h3FF);
    push_req(CMD_CROSS, 48'd50000);
    push_req(CMD_POLL, 48'd50001);
    push_req(CMD_POLL, 48'd51000);
    wait_idle();
    set_config(16'd16384, MODE_UNUSED, MILLE_CAP);
    push_req(CMD_CROSS, 48'd60000);
    push_req(CMD_POLL, 48'd60001);
    push_req(CMD_POLL, 48'd70500);
    cur = 48'd80000;

    n_items = 0;
    while (n_items < RANDOM_ITEMS) begin
      wait_idle();
      r = $urandom_range(0, 9);
      if (r == 0) d = 16'd0;
      else if (r == 1) d = DUTY_ALL;
      else if (r == 2) d = 16'd1;
      else if (r == 3) d = 16'd65534;
      else d = 16'($urandom);
      r = $urandom_range(0, 5);
      if (r == 0) p = 10'd0;
      else if (r == 1) p = MILLE_CAP;
      else if (r == 2) p = 10'h3FF;
      else p = 10'($urandom_range(0, 1023));
      set_config(d, 2'($urandom_range(0, 3)), p);
      calm = ($urandom_range(0, 3) == 0);

      r = $urandom_range(0, 9);
      if (r == 0) begin
        hi = $urandom;
        cur = {hi[15:0], 32'($urandom)};
      end else if (r == 1) begin
        cur = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 30000));
      end else if (r == 2) begin
        cur = '0;
      end
      push_req(CMD_CROSS, cur);

      k = $urandom_range(3, 8);
      repeat (k) begin
        r = $urandom_range(0, 99);
        if (r < 70) hp = $urandom_range(6000, 12000);
        else if (r < 85) hp = $urandom_range(4990, 5100);
        else if (r < 95) hp = $urandom_range(20000, 2000000);
        else hp = 0;
        if (hp == 0) begin
          // gap past 32 bits: the measured period saturates
          cur = cur + {16'h0001, 32'($urandom)};
          hp = $urandom_range(6000, 12000);
        end else begin
          cur = cur + 48'(hp);
        end
        push_req(CMD_CROSS, cur);

        r = $urandom_range(0, 99);
        if (r < 5) begin
          hi = $urandom;
          push_req(1'($urandom_range(0, 1)), {hi[15:0], 32'($urandom)});
        end else if (r < 15) begin
          r = $urandom_range(0, 3);
          if (r == 0) off = 32'd0;
          else if (r == 1) off = NOISE_MAX;
          else if (r == 2) off = NOISE_MAX + 32'd1;
          else off = $urandom_range(1, 4999);
          push_req(CMD_CROSS, cur + {16'd0, off});
        end

        off = 32'd0;
        repeat ($urandom_range(1, 9)) begin
          off = off + $urandom_range(1, hp / 3 + 1);
          push_req(CMD_POLL, cur + {16'd0, off});
        end
      end
    end

    wait_idle();
    if (errors == 0 && result_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #8000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
